// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the per-bin usage statistics RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/core/pbu_pkg.sv -----
// Types and constants of the per-bin usage statistics block.
// No dependencies; imported by the top-level module of the block.
package pbu_pkg;

   localparam int TOTAL_W = 48;
   localparam int COUNT_W = 16;
   localparam int ENTRY_W = TOTAL_W + COUNT_W;
   localparam int SUM_W   = 56;
   localparam int OUT_W   = 56;
   localparam int ACC_W   = 120;
   localparam int CNT_W   = 9;
   localparam int HALF_W  = 28;
   localparam int SQ_W    = 112;
   localparam int ACT_W   = 7;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [ACT_W-1:0]   ACT_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_STATS = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_NO_DATA  = 2'd2,
      ST_SATURATE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OP, S_SUM, S_SUM_E, S_MDIV, S_MDIV_W, S_DEV_RD, S_DEV_D,
      S_DEV_M, S_DEV_E, S_VDIV, S_VDIV_W, S_SQ_W, S_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  bin_index;
      logic [39:0] sample_ns;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [TOTAL_W-1:0] bin_total;
      logic [COUNT_W-1:0] bin_items;
      logic [OUT_W-1:0]   mean_usage;
      logic [OUT_W-1:0]   deviation_usage;
   } rsp_type;

endpackage

// ----- rtl/core/per_bin_usage_mean_deviation_unit.sv -----
// Per-bin usage accumulator top level: table RAM, sequencer, divider, root.
// Depends on pbu_pkg, pbu_ram, pbu_div, pbu_sqrt and assert_macros.svh.
//
// One request is worked on at a time. For clear, add and read, the accept
// cycle issues the table read; the S_OP state then modifies, writes back
// and posts the result once the output register is free. A statistics
// request walks the n active bins twice through the single RAM read port
// and then uses the shared one-bit-per-cycle divider twice and the root
// unit once. A result waits in an output register, so the next request is
// taken while it is still pending. Clear takes effect at once through
// per-bin valid bits; there is no clearing pass after reset.
`include "assert_macros.svh"

module per_bin_usage_mean_deviation_unit
   import pbu_pkg::*;
#(
   parameter int BIN_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [ACT_W-1:0] csr_data
);

   localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam logic [CNT_W-1:0] BINS = CNT_W'(BIN_COUNT);

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [5:0]           idx_ff, idx_in;
   logic [39:0]          usage_ff, usage_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 sum_pend_ff, sum_pend_in;
   logic [OUT_W-1:0]     mean_ff, mean_in;
   logic [OUT_W-1:0]     d_ff, d_in;
   logic [1:0]           ph_ff, ph_in;
   logic [2*HALF_W-1:0]  prod_ff, prod_in;
   logic [1:0]           prod_sh_ff, prod_sh_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [OUT_W-1:0]     dev_ff, dev_in;
   logic [COUNT_W-1:0]   samples_ff, samples_in;
   logic [BIN_COUNT-1:0] vld_ff, vld_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [ACT_W-1:0]     active_ff, active_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]   ram_wdata, ram_rdata, entry;
   logic [TOTAL_W-1:0]   tot;
   logic [COUNT_W-1:0]   itm;
   logic [TOTAL_W:0]     sum49;
   logic [CNT_W-1:0]     act9, n_eff, n_last;
   logic                 in_range, slot_free, fire, accept;
   logic                 div_start, div_done, sq_start, sq_done;
   logic                 div_wait;
   logic [ACC_W-1:0]     div_dividend, div_q;
   logic [SQ_W/2-1:0]    sq_root;
   logic [OUT_W-1:0]     x256;
   logic [HALF_W-1:0]    mul_a, mul_b;
   logic [ACC_W-1:0]     prod_wide;

   pbu_ram #(.WIDTH(ENTRY_W), .DEPTH(BIN_COUNT)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pbu_div #(.DW(ACC_W), .VW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   pbu_sqrt #(.RW(SQ_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_q[SQ_W-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   // clamp active bin count to 1 .. BIN_COUNT
   always_comb begin
      act9 = CNT_W'(active_ff);
      if (act9 == '0) begin
         n_eff = CNT_W'(1);
      end else if (act9 > BINS) begin
         n_eff = BINS;
      end else begin
         n_eff = act9;
      end
      n_last = n_eff - 1'b1;
   end

   // entries never written since clear read as zero
   assign entry     = rd_vld_ff ? ram_rdata : '0;
   assign tot       = entry[ENTRY_W-1:COUNT_W];
   assign itm       = entry[COUNT_W-1:0];
   assign in_range  = CNT_W'(idx_ff) < n_eff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign sum49     = {1'b0, tot} + (TOTAL_W + 1)'(usage_ff);
   assign x256      = {tot, 8'b0};

   // multiplier operand select: low*low, high*low, high*high
   always_comb begin
      case (ph_ff)
         2'd0: begin
            mul_a = d_ff[HALF_W-1:0];
            mul_b = d_ff[HALF_W-1:0];
         end
         2'd1: begin
            mul_a = d_ff[2*HALF_W-1:HALF_W];
            mul_b = d_ff[HALF_W-1:0];
         end
         default: begin
            mul_a = d_ff[2*HALF_W-1:HALF_W];
            mul_b = d_ff[2*HALF_W-1:HALF_W];
         end
      endcase
   end

   // align a partial product; cross term counts twice
   always_comb begin
      case (prod_sh_ff)
         2'd0:    prod_wide = ACC_W'(prod_ff);
         2'd1:    prod_wide = ACC_W'(prod_ff) << (HALF_W + 1);
         default: prod_wide = ACC_W'(prod_ff) << (2 * HALF_W);
      endcase
   end

   // sequencer: next state, datapath updates, RAM and unit controls
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      usage_in     = usage_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_pend_ff ? sum_ff + SUM_W'(tot) : sum_ff;
      sum_pend_in  = 1'b0;
      mean_in      = mean_ff;
      d_in         = d_ff;
      ph_in        = ph_ff;
      prod_in      = prod_ff;
      prod_sh_in   = prod_sh_ff;
      prod_vld_in  = 1'b0;
      acc_in       = prod_vld_ff ? acc_ff + prod_wide : acc_ff;
      dev_in       = dev_ff;
      samples_in   = samples_ff;
      vld_in       = vld_ff;
      active_in    = csr_valid ? csr_data : active_ff;
      rsp_in       = rsp_ff;
      fire         = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = AW'(idx_ff);
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = AW'(cnt_ff);
      div_start    = 1'b0;
      div_dividend = acc_ff;
      sq_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.opcode;
               idx_in    = req_data.bin_index;
               usage_in  = req_data.sample_ns;
               ram_re    = 1'b1;
               ram_raddr = AW'(req_data.bin_index);
               state_in  = S_OP;
            end
         end
         S_OP: begin
            if (slot_free) begin
               rsp_in   = '0;
               state_in = S_IDLE;
               fire     = 1'b1;
               case (op_ff)
                  OP_CLEAR: begin
                     vld_in     = '0;
                     samples_in = '0;
                  end
                  OP_ADD: begin
                     if (!in_range) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        ram_we = 1'b1;
                        ram_wdata[COUNT_W-1:0] = (itm == COUNT_MAX) ? itm : itm + 1'b1;
                        if (sum49[TOTAL_W]) begin
                           ram_wdata[ENTRY_W-1:COUNT_W] = TOTAL_MAX;
                           rsp_in.status = ST_SATURATE;
                        end else begin
                           ram_wdata[ENTRY_W-1:COUNT_W] = sum49[TOTAL_W-1:0];
                        end
                        vld_in[AW'(idx_ff)] = 1'b1;
                        if (samples_ff != COUNT_MAX) begin
                           samples_in = samples_ff + 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (!in_range) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        rsp_in.bin_total = tot;
                        rsp_in.bin_items = itm;
                     end
                  end
                  default: begin
                     if (samples_ff == '0) begin
                        rsp_in.status = ST_NO_DATA;
                     end else begin
                        fire     = 1'b0;
                        rsp_in   = rsp_ff;
                        cnt_in   = '0;
                        sum_in   = '0;
                        state_in = S_SUM;
                     end
                  end
               endcase
            end
         end
         // first walk: sum of totals
         S_SUM: begin
            ram_re      = 1'b1;
            sum_pend_in = 1'b1;
            if (cnt_ff == n_last) begin
               state_in = S_SUM_E;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SUM_E: state_in = S_MDIV;
         S_MDIV: begin
            div_start    = 1'b1;
            div_dividend = ACC_W'({sum_ff, 8'b0});
            state_in     = S_MDIV_W;
         end
         S_MDIV_W: begin
            if (div_done) begin
               mean_in  = div_q[OUT_W-1:0];
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_DEV_RD;
            end
         end
         // second walk: sum of squared deviations
         S_DEV_RD: begin
            ram_re   = 1'b1;
            state_in = S_DEV_D;
         end
         S_DEV_D: begin
            d_in     = (x256 >= mean_ff) ? x256 - mean_ff : mean_ff - x256;
            ph_in    = 2'd0;
            state_in = S_DEV_M;
         end
         S_DEV_M: begin
            prod_in     = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
            prod_sh_in  = ph_ff;
            prod_vld_in = 1'b1;
            if (ph_ff == 2'd2) begin
               if (cnt_ff == n_last) begin
                  state_in = S_DEV_E;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_DEV_RD;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         S_DEV_E: state_in = S_VDIV;
         S_VDIV: begin
            div_start = 1'b1;
            state_in  = S_VDIV_W;
         end
         S_VDIV_W: begin
            if (div_done) begin
               sq_start = 1'b1;
               state_in = S_SQ_W;
            end
         end
         S_SQ_W: begin
            if (sq_done) begin
               dev_in   = OUT_W'(sq_root);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_in                 = '0;
               rsp_in.mean_usage      = mean_ff;
               rsp_in.deviation_usage = dev_ff;
               fire                   = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rd_vld_in    = ram_re ? vld_ff[ram_raddr] : rd_vld_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_pend_ff  <= 1'b0;
         prod_vld_ff  <= 1'b0;
         samples_ff   <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         active_ff    <= ACT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_pend_ff  <= sum_pend_in;
         prod_vld_ff  <= prod_vld_in;
         samples_ff   <= samples_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= rd_vld_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      usage_ff   <= usage_in;
      cnt_ff     <= cnt_in;
      sum_ff     <= sum_in;
      mean_ff    <= mean_in;
      d_ff       <= d_in;
      ph_ff      <= ph_in;
      prod_ff    <= prod_in;
      prod_sh_ff <= prod_sh_in;
      acc_ff     <= acc_in;
      dev_ff     <= dev_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer states that wait on the divider
   assign div_wait = (state_ff == S_MDIV_W) || (state_ff == S_VDIV_W);

   `ASSERT_NEXT(a_accept_to_op, clock, reset, accept, state_ff == S_OP, "no op after accept")
   `ASSERT_IMPLIES(a_div_done_wait, clock, reset, div_done, div_wait, "divider done early")
   `ASSERT_IMPLIES(a_sq_done_wait, clock, reset, sq_done, state_ff == S_SQ_W, "root done early")

endmodule

// ----- rtl/core/pbu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-bin table.
module pbu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pbu_div.sv -----
// Restoring divider, one quotient bit per cycle, small divisor.
// Depends on nothing; shared by the mean and variance steps.
module pbu_div #(
   parameter int DW = 120,
   parameter int VW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] q_ff, q_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] div_ff, div_in;
   logic [VW:0]   trial;
   logic          ge;

   // one shift-compare-subtract step
   always_comb begin
      trial   = {rem_ff, q_ff[DW-1]};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? VW'(trial - {1'b0, div_ff}) : VW'(trial);
         q_in   = {q_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- rtl/core/pbu_sqrt.sv -----
// Integer square root, one root bit per cycle (two radicand bits a step).
// Depends on nothing; used for the deviation.
module pbu_sqrt #(
   parameter int RW = 112
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RW-1:0]      radicand,
   output logic               done,
   output logic [RW/2-1:0]    root
);

   localparam int HW = RW / 2;
   localparam int R2 = HW + 4;
   localparam int CW = $clog2(HW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rad_ff, rad_in;
   logic [HW-1:0] root_ff, root_in;
   logic [R2-1:0] rem_ff, rem_in;
   logic [R2-1:0] rem_t, trial;
   logic          ge;

   // bring down two bits, try root*4+1
   always_comb begin
      rem_t   = {rem_ff[R2-3:0], rad_ff[RW-1:RW-2]};
      trial   = R2'({root_ff, 2'b01});
      ge      = rem_t >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_t - trial : rem_t;
         root_in = {root_ff[HW-2:0], ge};
         rad_in  = {rad_ff[RW-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(HW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
